// ----- sv/ptcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_pkg
// Shared types, constants and small arithmetic helpers for the closest point
// on triangle core.
// ----------------------------------------------------------------------------
package ptcp_pkg;

  // reduced vector precision
  localparam int RED_BITS = 14;
  localparam int RW       = 15;
  localparam int QBITS    = 30;

  // fixed weights and limits
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] THIRD_Q30 = 31'd357913941;
  localparam logic [62:0] DIST_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] SQ_LIMIT  = 32'd3037000499;

  // how the back end finishes a word
  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_EDGE  = 2'd2;

  // divider special cases
  localparam logic [1:0] DIV_NORM = 2'd0;
  localparam logic [1:0] DIV_ONE  = 2'd1;
  localparam logic [1:0] DIV_ZERO = 2'd2;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        edge_sel;
    logic [2:0][30:0]  wt;
    logic [61:0]       na;
    logic [61:0]       da;
    logic [61:0]       nb;
    logic [61:0]       db;
  } ptcp_ctl_t;

  function automatic logic signed [31:0] mul15(input logic signed [14:0] a,
                                               input logic signed [14:0] b);
    logic signed [31:0] ax;
    logic signed [31:0] bx;
    ax = 32'(a);
    bx = 32'(b);
    return ax * bx;
  endfunction

  function automatic logic signed [33:0] mul16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [33:0] ax;
    logic signed [33:0] bx;
    ax = 34'(a);
    bx = 34'(b);
    return ax * bx;
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = 64'(a);
    bx = 64'(b);
    return ax * bx;
  endfunction

  function automatic logic [1:0] div_flag(input logic [61:0] n, input logic [61:0] d);
    logic [1:0] f;
    if (d == '0) f = DIV_ZERO;
    else if (n >= d) f = DIV_ONE;
    else f = DIV_NORM;
    return f;
  endfunction

endpackage

// ----- sv/ptcp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_front
// Accepts words, reduces the edge vectors, forms dot products and the
// barycentric numerators, and classifies each word into fixed, interior or
// edge handling for the back end.
// ----------------------------------------------------------------------------
module ptcp_front
  import ptcp_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [12*CW-1:0]      in_pts,
  input  logic                  q_full,
  output logic                  q_wr,
  output ptcp_ctl_t             q_ctl,
  output logic [9*(CW+1)-1:0]   q_crd
);

  localparam int DW  = CW + 1;
  localparam int CV  = 9 * DW;
  localparam int SW  = $clog2(CW + 1);
  localparam int NFS = 7;

  logic           en_f;
  logic [NFS-1:0] vf_r;
  logic [CV-1:0]  crd_r [NFS];
  logic [CV-1:0]  crd_nxt;

  logic [CW-1:0]  m_or;
  logic [CW-1:0]  sp;
  logic [SW-1:0]  bl;
  logic [SW-1:0]  sh_nxt;
  logic [SW-1:0]  sh_r;
  logic signed [DW-1:0] shf;
  logic signed [RW-1:0] red_nxt [9];
  logic signed [RW-1:0] red_r   [9];

  logic signed [31:0] d11_r, d22_r, d12_r, d1p_r, d2p_r;
  logic signed [15:0] ev_r [3][3];
  logic signed [15:0] ew_r [3][3];
  logic signed [31:0] v22, v33;

  logic signed [63:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [33:0] len5_r [3], along5_r [3], dd5_r [3];
  logic signed [63:0] det6_r, n1_6_r, n2_6_r;
  logic signed [33:0] len6_r [3], along6_r [3], dd6_r [3];
  logic signed [63:0] det7_r, n0_r, n1_r, n2_r;
  logic signed [33:0] len7_r [3], along7_r [3], dd7_r [3];

  ptcp_ctl_t          ctl;
  logic               have;
  logic               done;
  logic signed [33:0] best;
  logic signed [33:0] ddv;
  logic [1:0]         endi;
  logic [2:0]         neg;

  // pipeline holds only when the last stage cannot enter the queue
  assign en_f     = !(vf_r[NFS-1] && q_full);
  assign in_stall = !en_f;
  assign q_wr     = vf_r[NFS-1] && !q_full;
  assign q_crd    = crd_r[NFS-1];
  assign q_ctl    = ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en_f) begin
      vf_r <= {vf_r[NFS-2:0], in_valid};
    end
  end

  // stage 1: edge and query offsets from corner 0
  always_comb begin
    crd_nxt = '0;
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < 3; k++) begin
        crd_nxt[(g*3+k)*DW +: DW] =
          {in_pts[((g+1)*3+k)*CW + CW-1], in_pts[((g+1)*3+k)*CW +: CW]} -
          {in_pts[k*CW + CW-1], in_pts[k*CW +: CW]};
      end
    end
  end

  // stage 2: common shift from the widest span
  always_comb begin
    m_or = '0;
    sp   = '0;
    for (int i = 0; i < 9; i++) begin
      sp   = crd_r[0][i*DW + DW-1] ? ~crd_r[0][i*DW +: CW] : crd_r[0][i*DW +: CW];
      m_or = m_or | sp;
    end
    bl = '0;
    for (int b = 0; b < CW; b++) begin
      if (m_or[b]) bl = SW'(b + 1);
    end
    sh_nxt = (bl > SW'(RED_BITS)) ? (bl - SW'(RED_BITS)) : '0;
  end

  // stage 3: reduced vectors, floor shift
  always_comb begin
    shf = '0;
    for (int i = 0; i < 9; i++) begin
      shf        = $signed(crd_r[1][i*DW +: DW]) >>> sh_r;
      red_nxt[i] = shf[RW-1:0];
    end
  end

  assign v22 = (d11_r == 0) ? 32'sd1 : d11_r;
  assign v33 = (d22_r == 0) ? 32'sd1 : d22_r;

  always_ff @(posedge clk) begin
    if (en_f) begin
      crd_r[0] <= crd_nxt;
      for (int i = 1; i < NFS; i++) crd_r[i] <= crd_r[i-1];
      sh_r <= sh_nxt;
      for (int i = 0; i < 9; i++) red_r[i] <= red_nxt[i];

      // stage 4: dot products and per-edge vectors
      d11_r <= mul15(red_r[0], red_r[0]) + mul15(red_r[1], red_r[1]) +
               mul15(red_r[2], red_r[2]);
      d22_r <= mul15(red_r[3], red_r[3]) + mul15(red_r[4], red_r[4]) +
               mul15(red_r[5], red_r[5]);
      d12_r <= mul15(red_r[0], red_r[3]) + mul15(red_r[1], red_r[4]) +
               mul15(red_r[2], red_r[5]);
      d1p_r <= mul15(red_r[0], red_r[6]) + mul15(red_r[1], red_r[7]) +
               mul15(red_r[2], red_r[8]);
      d2p_r <= mul15(red_r[3], red_r[6]) + mul15(red_r[4], red_r[7]) +
               mul15(red_r[5], red_r[8]);
      for (int k = 0; k < 3; k++) begin
        ev_r[0][k] <= 16'(red_r[k]);
        ew_r[0][k] <= 16'(red_r[6+k]);
        ev_r[1][k] <= 16'(red_r[3+k]) - 16'(red_r[k]);
        ew_r[1][k] <= 16'(red_r[6+k]) - 16'(red_r[k]);
        ev_r[2][k] <= 16'sd0 - 16'(red_r[3+k]);
        ew_r[2][k] <= 16'(red_r[6+k]) - 16'(red_r[3+k]);
      end

      // stage 5: cramer products and edge projections
      pa_r <= mul32(v22, v33);
      pb_r <= mul32(d12_r, d12_r);
      pc_r <= mul32(v22, d2p_r);
      pd_r <= mul32(d12_r, d1p_r);
      pe_r <= mul32(v33, d1p_r);
      pf_r <= mul32(d12_r, d2p_r);
      for (int i = 0; i < 3; i++) begin
        len5_r[i]   <= mul16(ev_r[i][0], ev_r[i][0]) + mul16(ev_r[i][1], ev_r[i][1]) +
                       mul16(ev_r[i][2], ev_r[i][2]);
        along5_r[i] <= mul16(ev_r[i][0], ew_r[i][0]) + mul16(ev_r[i][1], ew_r[i][1]) +
                       mul16(ev_r[i][2], ew_r[i][2]);
        dd5_r[i]    <= mul16(ew_r[i][0], ew_r[i][0]) + mul16(ew_r[i][1], ew_r[i][1]) +
                       mul16(ew_r[i][2], ew_r[i][2]);
      end

      // stage 6: determinant and numerators
      det6_r <= pa_r - pb_r;
      n2_6_r <= pc_r - pd_r;
      n1_6_r <= pe_r - pf_r;
      for (int i = 0; i < 3; i++) begin
        len6_r[i]   <= len5_r[i];
        along6_r[i] <= along5_r[i];
        dd6_r[i]    <= dd5_r[i];
      end

      // stage 7: third numerator
      det7_r <= det6_r;
      n0_r   <= det6_r - n1_6_r - n2_6_r;
      n1_r   <= n1_6_r;
      n2_r   <= n2_6_r;
      for (int i = 0; i < 3; i++) begin
        len7_r[i]   <= len6_r[i];
        along7_r[i] <= along6_r[i];
        dd7_r[i]    <= dd6_r[i];
      end
    end
  end

  // classification and edge walk
  always_comb begin
    ctl      = '0;
    ctl.mode = MODE_FIXED;
    have     = 1'b0;
    done     = 1'b0;
    best     = '0;
    ddv      = '0;
    endi     = '0;
    neg      = {n1_r[63], n0_r[63], n2_r[63]};
    if (det7_r <= 0) begin
      ctl.wt[0] = ONE_Q30 - THIRD_Q30 - THIRD_Q30;
      ctl.wt[1] = THIRD_Q30;
      ctl.wt[2] = THIRD_Q30;
    end else if (neg == 3'b000) begin
      ctl.mode = MODE_INTER;
      ctl.na   = n1_r[61:0];
      ctl.da   = det7_r[61:0];
      ctl.nb   = n2_r[61:0];
      ctl.db   = det7_r[61:0];
    end else begin
      ctl.wt[0] = ONE_Q30;
      for (int i = 0; i < 3; i++) begin
        if (!done && neg[i]) begin
          if (along7_r[i] <= 0 || along7_r[i] >= len7_r[i]) begin
            endi = (along7_r[i] <= 0) ? 2'(i) : ((i == 2) ? 2'd0 : 2'(i + 1));
            ddv  = dd7_r[endi];
            if (!have || ddv < best) begin
              have         = 1'b1;
              best         = ddv;
              ctl.wt       = '0;
              ctl.wt[endi] = ONE_Q30;
            end
          end else begin
            done         = 1'b1;
            ctl.mode     = MODE_EDGE;
            ctl.edge_sel = 2'(i);
            ctl.na       = 62'(along7_r[i]);
            ctl.da       = 62'(len7_r[i]);
          end
        end
      end
    end
  end

endmodule

// ----- sv/ptcp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ptcp_queue
  import ptcp_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0]   mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- sv/ptcp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_back
// Pipelined radix-2 dividers for the weights, weight assembly, closest point
// blend and saturating squared distance.
// ----------------------------------------------------------------------------
module ptcp_back
  import ptcp_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_rd,
  input  ptcp_ctl_t            q_ctl,
  input  logic [9*(CW+1)-1:0]  q_crd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [30:0]          out_weight0,
  output logic [30:0]          out_weight1,
  output logic [30:0]          out_weight2,
  output logic [62:0]          out_dist_squared
);

  localparam int DW  = CW + 1;
  localparam int CV  = 9 * DW;
  localparam int EW  = (DW > 28) ? DW : 28;
  localparam int HW  = EW + 13;
  localparam int TW  = HW + 21;
  localparam int BLW = EW + 4;
  localparam int DFW = BLW + 1;
  localparam int NBV = QBITS + 6;

  logic            en_b;
  logic [NBV-1:0]  bv_r;
  logic            out_valid_r;

  ptcp_ctl_t       ctl_r [QBITS+1];
  logic [CV-1:0]   crd_r [QBITS+1];
  logic [61:0]     ra_r  [QBITS+1];
  logic [61:0]     rb_r  [QBITS+1];
  logic [61:0]     da_r  [QBITS+1];
  logic [61:0]     db_r  [QBITS+1];
  logic [QBITS-1:0] qa_r [QBITS+1];
  logic [QBITS-1:0] qb_r [QBITS+1];
  logic [1:0]      fa_r  [QBITS+1];
  logic [1:0]      fb_r  [QBITS+1];

  logic [62:0]     ta_a [QBITS], sa_a [QBITS], tb_a [QBITS], sb_a [QBITS];
  logic            gea  [QBITS], geb  [QBITS];

  logic [30:0]     qa_fin, qb_fin;
  logic [2:0][30:0] w_nxt;
  logic [2:0][30:0] w31_r, w32_r, w33_r, w34_r, w35_r;
  logic [CV-1:0]   c31_r, c32_r, c33_r;

  logic signed [EW-1:0]    x1, x2;
  logic signed [EW-21:0]   h1, h2;
  logic [19:0]             l1, l2;
  logic signed [HW-1:0]    hi_nxt [3], hi_r [3];
  logic [51:0]             lo_nxt [3], lo_r [3];
  logic signed [TW-1:0]    tot;
  logic signed [BLW-1:0]   bl_nxt [3], bl_r [3];
  logic signed [DFW-1:0]   pe, be, df;
  logic [DFW-1:0]          mg;
  logic [31:0]             mag_nxt [3], mag_r [3];
  logic                    sat_nxt, sat34_r, sat35_r;
  logic [63:0]             sq_r [3];
  logic [65:0]             sum;

  logic [30:0] w0_r, w1_r, w2_r;
  logic [62:0] dist_r;

  // back pipeline holds while a finished word waits
  assign en_b             = !(out_valid_r && out_stall);
  assign q_rd             = en_b && !q_empty;
  assign out_valid        = out_valid_r;
  assign out_weight0      = w0_r;
  assign out_weight1      = w1_r;
  assign out_weight2      = w2_r;
  assign out_dist_squared = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en_b) begin
      bv_r        <= {bv_r[NBV-2:0], !q_empty};
      out_valid_r <= bv_r[NBV-1];
    end
  end

  // one quotient bit per stage for both dividers
  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      ta_a[k] = {ra_r[k], 1'b0};
      sa_a[k] = ta_a[k] - {1'b0, da_r[k]};
      gea[k]  = (ta_a[k] >= {1'b0, da_r[k]});
      tb_a[k] = {rb_r[k], 1'b0};
      sb_a[k] = tb_a[k] - {1'b0, db_r[k]};
      geb[k]  = (tb_a[k] >= {1'b0, db_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      ctl_r[0] <= q_ctl;
      crd_r[0] <= q_crd;
      ra_r[0]  <= q_ctl.na;
      rb_r[0]  <= q_ctl.nb;
      da_r[0]  <= q_ctl.da;
      db_r[0]  <= q_ctl.db;
      qa_r[0]  <= '0;
      qb_r[0]  <= '0;
      fa_r[0]  <= div_flag(q_ctl.na, q_ctl.da);
      fb_r[0]  <= div_flag(q_ctl.nb, q_ctl.db);
      for (int k = 0; k < QBITS; k++) begin
        ctl_r[k+1] <= ctl_r[k];
        crd_r[k+1] <= crd_r[k];
        da_r[k+1]  <= da_r[k];
        db_r[k+1]  <= db_r[k];
        fa_r[k+1]  <= fa_r[k];
        fb_r[k+1]  <= fb_r[k];
        ra_r[k+1]  <= gea[k] ? sa_a[k][61:0] : ta_a[k][61:0];
        rb_r[k+1]  <= geb[k] ? sb_a[k][61:0] : tb_a[k][61:0];
        qa_r[k+1]  <= {qa_r[k][QBITS-2:0], gea[k]};
        qb_r[k+1]  <= {qb_r[k][QBITS-2:0], geb[k]};
      end
    end
  end

  // weight assembly
  always_comb begin
    unique case (fa_r[QBITS])
      DIV_ONE:  qa_fin = ONE_Q30;
      DIV_ZERO: qa_fin = '0;
      default:  qa_fin = {1'b0, qa_r[QBITS]};
    endcase
    unique case (fb_r[QBITS])
      DIV_ONE:  qb_fin = ONE_Q30;
      DIV_ZERO: qb_fin = '0;
      default:  qb_fin = {1'b0, qb_r[QBITS]};
    endcase
    w_nxt = ctl_r[QBITS].wt;
    unique case (ctl_r[QBITS].mode)
      MODE_INTER: begin
        w_nxt[1] = qa_fin;
        w_nxt[2] = qb_fin;
        w_nxt[0] = ONE_Q30 - qa_fin - qb_fin;
      end
      MODE_EDGE: begin
        unique case (ctl_r[QBITS].edge_sel)
          2'd0:    w_nxt = {31'd0, qa_fin, ONE_Q30 - qa_fin};
          2'd1:    w_nxt = {qa_fin, ONE_Q30 - qa_fin, 31'd0};
          default: w_nxt = {ONE_Q30 - qa_fin, 31'd0, qa_fin};
        endcase
      end
      default: w_nxt = ctl_r[QBITS].wt;
    endcase
  end

  // blend partial products, split at bit 20
  always_comb begin
    x1 = '0; x2 = '0; h1 = '0; h2 = '0; l1 = '0; l2 = '0;
    for (int k = 0; k < 3; k++) begin
      x1        = EW'($signed(c31_r[k*DW +: DW]));
      x2        = EW'($signed(c31_r[(3+k)*DW +: DW]));
      h1        = $signed(x1[EW-1:20]);
      h2        = $signed(x2[EW-1:20]);
      l1        = x1[19:0];
      l2        = x2[19:0];
      hi_nxt[k] = $signed({1'b0, w31_r[1]}) * h1 + $signed({1'b0, w31_r[2]}) * h2;
      lo_nxt[k] = w31_r[1] * l1 + w31_r[2] * l2;
    end
  end

  // recombine and floor divide by 2^30
  always_comb begin
    tot = '0;
    for (int k = 0; k < 3; k++) begin
      tot       = $signed({hi_r[k][HW-1], hi_r[k], 20'b0}) +
                  $signed({{(TW-52){1'b0}}, lo_r[k]});
      bl_nxt[k] = tot[TW-1:30];
    end
  end

  // offset magnitude and overflow check
  always_comb begin
    pe = '0; be = '0; df = '0; mg = '0;
    sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pe         = DFW'($signed(c33_r[(6+k)*DW +: DW]));
      be         = DFW'(bl_r[k]);
      df         = pe - be;
      mg         = df[DFW-1] ? DFW'(-df) : DFW'(df);
      sat_nxt    = sat_nxt | (mg > DFW'(SQ_LIMIT));
      mag_nxt[k] = mg[31:0];
    end
  end

  assign sum = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en_b) begin
      w31_r <= w_nxt;
      c31_r <= crd_r[QBITS];
      w32_r <= w31_r;
      c32_r <= c31_r;
      w33_r <= w32_r;
      c33_r <= c32_r;
      w34_r <= w33_r;
      w35_r <= w34_r;
      sat34_r <= sat_nxt;
      sat35_r <= sat34_r;
      for (int k = 0; k < 3; k++) begin
        hi_r[k]  <= hi_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        bl_r[k]  <= bl_nxt[k];
        mag_r[k] <= mag_nxt[k];
        sq_r[k]  <= mag_r[k] * mag_r[k];
      end
      // output word
      w0_r   <= w35_r[0];
      w1_r   <= w35_r[1];
      w2_r   <= w35_r[2];
      dist_r <= (sat35_r || sum > 66'(DIST_MAX)) ? DIST_MAX : sum[62:0];
    end
  end

endmodule

// ----- sv/point_triangle_closest_point_core.sv -----
`timescale 1ns / 1ps
// throughput: one word per cycle while out_stall is low, sustained by the 30-stage pipelined dividers
// a 4-entry queue decouples the 7-stage front end from the 37-stage back end
// reset: synchronous, clears all valid flags and the queue; no clearing pass
// ----------------------------------------------------------------------------
// point_triangle_closest_point_core
// Closest point of a triangle to a query point: barycentric weights in Q1.30
// and saturating squared distance in unsigned Q63.0.
// ----------------------------------------------------------------------------
module point_triangle_closest_point_core
  import ptcp_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_z,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [30:0]                   out_weight0,
  output logic [30:0]                   out_weight1,
  output logic [30:0]                   out_weight2,
  output logic [62:0]                   out_dist_squared
);

  localparam int CV = 9 * (COORD_WIDTH + 1);
  localparam int QW = $bits(ptcp_ctl_t) + CV;

  logic [12*COORD_WIDTH-1:0] pts;
  logic                      q_full, q_wr, q_empty, q_rd;
  ptcp_ctl_t                 f_ctl, b_ctl;
  logic [CV-1:0]             f_crd;
  logic [QW-1:0]             q_rdata;

  assign pts = {in_query_z, in_query_y, in_query_x,
                in_corner2_z, in_corner2_y, in_corner2_x,
                in_corner1_z, in_corner1_y, in_corner1_x,
                in_corner0_z, in_corner0_y, in_corner0_x};

  assign b_ctl = q_rdata[QW-1:CV];

  // front end: reduce and classify
  ptcp_front #(.CW(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pts   (pts),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_ctl    (f_ctl),
    .q_crd    (f_crd)
  );

  // queue between the two halves
  ptcp_queue #(.W(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data ({f_ctl, f_crd}),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back end: divide, blend, distance
  ptcp_back #(.CW(COORD_WIDTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rd             (q_rd),
    .q_ctl            (b_ctl),
    .q_crd            (q_rdata[CV-1:0]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight0      (out_weight0),
    .out_weight1      (out_weight1),
    .out_weight2      (out_weight2),
    .out_dist_squared (out_dist_squared)
  );

endmodule

// ----- sv/ptcp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcp_checker
// Port-level checks on the result channel of the closest point core.
// ----------------------------------------------------------------------------
module ptcp_checker
  import ptcp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_weight0,
  input logic [30:0] out_weight1,
  input logic [30:0] out_weight2,
  input logic [62:0] out_dist_squared
);

  // a stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_weight0) && $stable(out_weight1) &&
                               $stable(out_weight2) && $stable(out_dist_squared))
    else $error("result payload changed while stalled");

  // weights of every valid result word sum to one
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (33'(out_weight0) + 33'(out_weight1) + 33'(out_weight2)
                   == 33'(ONE_Q30)))
    else $error("weights do not sum to one");

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind point_triangle_closest_point_core ptcp_checker u_ptcp_checker (.*);
